// ----- sv/lxc_pkg.sv -----
// Shared codes, character constants and helpers for the line XOR checksum checker.
`timescale 1ns / 1ps
`default_nettype none

package lxc_pkg;

  // Parse phase codes
  localparam logic [2:0] PH_START     = 3'd0;
  localparam logic [2:0] PH_XOR       = 3'd1;
  localparam logic [2:0] PH_HEX1      = 3'd2;
  localparam logic [2:0] PH_HEX2      = 3'd3;
  localparam logic [2:0] PH_DONE      = 3'd4;
  localparam logic [2:0] PH_ERROR     = 3'd5;
  localparam logic [2:0] PH_UNCHECKED = 3'd6;

  // Line status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ABSENT    = 3'd1;
  localparam logic [2:0] ST_MISMATCH  = 3'd2;
  localparam logic [2:0] ST_SYNTAX    = 3'd3;
  localparam logic [2:0] ST_UNCHECKED = 3'd4;

  // Characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;

  typedef struct packed {
    logic [2:0] check_status;
    logic [7:0] computed_xor;
    logic [7:0] received_xor;
  } lxc_result_t;

  // Bit 4 set: not an upper-case hex digit. Bits 3:0: digit value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] diff;
    begin
      diff = 8'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        diff = c - CH_ZERO;
        hex_digit = {1'b0, diff[3:0]};
      end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
        diff = c - CH_UPPER_A + 8'd10;
        hex_digit = {1'b0, diff[3:0]};
      end else begin
        hex_digit = 5'b10000;
      end
    end
  endfunction

endpackage

`default_nettype wire

// ----- sv/lxc_parser.sv -----
// Per-character line parser: phase, XOR accumulator, received digits and line status.
`timescale 1ns / 1ps
`default_nettype none

module lxc_parser
  import lxc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic [7:0]  line_char,
  input  wire logic        end_of_line,
  output lxc_result_t      result
);

  logic [2:0] phase, phase_next;
  logic [7:0] acc, acc_next;
  logic [7:0] rxv, rxv_next;
  logic [4:0] digit;

  assign digit = hex_digit(line_char);

  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    rxv_next   = rxv;
    case (phase)
      PH_START: begin
        phase_next = (line_char == CH_DOLLAR) ? PH_XOR : PH_UNCHECKED;
      end
      PH_XOR: begin
        if (line_char == CH_STAR) phase_next = PH_HEX1;
        else acc_next = acc ^ line_char;
      end
      PH_HEX1: begin
        if (!digit[4]) begin
          rxv_next   = {4'd0, digit[3:0]};
          phase_next = PH_HEX2;
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_HEX2: begin
        if (!digit[4]) begin
          rxv_next   = {rxv[3:0], digit[3:0]};
          phase_next = PH_DONE;
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_UNCHECKED: phase_next = PH_UNCHECKED;
      default:      phase_next = PH_ERROR;
    endcase
  end

  // Status as seen if this character closes the line
  always_comb begin
    case (phase_next)
      PH_XOR:       result.check_status = ST_ABSENT;
      PH_DONE:      result.check_status = (acc_next == rxv_next) ? ST_OK : ST_MISMATCH;
      PH_UNCHECKED: result.check_status = ST_UNCHECKED;
      default:      result.check_status = ST_SYNTAX;
    endcase
    result.computed_xor = (phase_next == PH_UNCHECKED) ? 8'd0 : acc_next;
    result.received_xor = (phase_next == PH_UNCHECKED || phase_next == PH_XOR)
                          ? 8'd0 : rxv_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      acc   <= 8'd0;
      rxv   <= 8'd0;
    end else if (step) begin
      if (end_of_line) begin
        phase <= PH_START;
        acc   <= 8'd0;
        rxv   <= 8'd0;
      end else begin
        phase <= phase_next;
        acc   <= acc_next;
        rxv   <= rxv_next;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/line_xor_checksum_checker.sv -----
// Top level of the line XOR checksum checker: parser plus result register.
`timescale 1ns / 1ps
`default_nettype none

// Checks command lines in the NMEA style. Characters arrive one per
// transaction on the input channel, the last one of a line flagged by
// end_of_line. A line starting with '$' has every character after the '$'
// XORed up to the first '*' or the line end; after '*' exactly two upper-case
// hex digits must follow, then the line must end. Each line yields exactly one
// output transaction on its last character: check_status (0 ok, 1 no checksum,
// 2 mismatch, 3 syntax error, 4 unchecked line), computed_xor and received_xor.
// Other characters produce nothing. The block takes one character per cycle:
// the parser state is registered per character and the status lands in a one-deep
// output register, so input stalls only while that register holds a result the
// consumer has not taken. out_valid rises in the cycle after the closing
// character is accepted.

module line_xor_checksum_checker
  import lxc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] line_char,
  input  wire logic       end_of_line,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      check_status,
  output logic [7:0]      computed_xor,
  output logic [7:0]      received_xor
);

  logic        in_fire;
  lxc_result_t line_result;
  lxc_result_t held;

  // Input may move whenever the result slot is empty or being drained.
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  lxc_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (in_fire),
    .line_char   (line_char),
    .end_of_line (end_of_line),
    .result      (line_result)
  );

  // Result register: loads on a line-closing transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && end_of_line) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && end_of_line) begin
      held <= line_result;
    end
  end

  assign check_status = held.check_status;
  assign computed_xor = held.computed_xor;
  assign received_xor = held.received_xor;

  // A line-closing transaction always yields a result next cycle.
  a_eol_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_fire && end_of_line |=> out_valid)
    else $error("line end did not produce a result");

  // A mid-line character never creates a result out of an empty slot.
  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    in_fire && !end_of_line && !out_valid |=> !out_valid)
    else $error("result produced without line end");

  // Unchecked lines report zero values.
  a_unchecked_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && check_status == ST_UNCHECKED |-> computed_xor == 8'd0 && received_xor == 8'd0)
    else $error("unchecked line with nonzero values");

  // Missing checksum reports zero received value.
  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && check_status == ST_ABSENT |-> received_xor == 8'd0)
    else $error("absent checksum with nonzero received value");

  // OK only when the values agree.
  a_ok_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && check_status == ST_OK |-> computed_xor == received_xor)
    else $error("ok status with differing values");

endmodule

`default_nettype wire

// ----- sim/line_xor_checksum_checker_tb.sv -----
// Self-checking testbench for the line XOR checksum checker: directed and random lines.
`timescale 1ns / 1ps

// Feeds command lines one character per transaction and checks every status
// transaction against a local parse of the same characters.
//  - An initial block builds the whole character stream up front: a short
//    directed set of corner lines, then random lines, mostly well formed
//    ('$', body, '*', two upper-case digits) with a share of broken and
//    unchecked lines mixed in.
//  - The driver pops characters at the falling edge and holds each until it
//    is taken. Some characters carry a drain mark: the driver holds them back
//    until every pending status has come out.
//  - The monitor samples both channels at the rising edge. An accepted
//    character advances the local parser; an end of line queues one
//    expected status. An accepted status is compared with the oldest one.
//  - The receiver drops ready at random, and once holds it low for a long
//    stretch so that the output register fills and the input stalls.
module line_xor_checksum_checker_tb;
  import lxc_pkg::*;

  localparam int          RANDOM_CHARS = 650;
  localparam int          DRAIN_AT     = 300;   // random chars before the second drain
  localparam int          IDLE_PCT     = 16;
  localparam int          QUIET_FROM   = 400;   // cycle window with no idling on
  localparam int          QUIET_TO     = 700;   // either side
  localparam int          HOLD_AFTER   = 20;    // statuses seen before the long hold-off
  localparam int          HOLD_CYCLES  = 80;
  localparam int          TAIL_CYCLES  = 10;
  localparam int          SHOW_ERRORS  = 10;
  localparam logic [7:0]  CH_LOWER_A   = 8'h61;
  localparam logic [7:0]  CH_UPPER_X   = 8'h58;

  typedef struct {
    logic [7:0] ch;
    logic       eol;
    bit         drain;   // hold back until no status is pending
  } char_txn_t;

  // ---------------------------------------------------------------- DUT ports
  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  logic [7:0] line_char   = 8'd0;
  logic       end_of_line = 1'b0;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  logic [2:0] check_status;
  logic [7:0] computed_xor;
  logic [7:0] received_xor;

  line_xor_checksum_checker u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .line_char    (line_char),
    .end_of_line  (end_of_line),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .check_status (check_status),
    .computed_xor (computed_xor),
    .received_xor (received_xor)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ------------------------------------------------------------ shared state
  char_txn_t   char_q[$];           // characters not yet offered
  char_txn_t   line_buf[$];         // line under construction
  lxc_result_t pending_status_q[$]; // statuses owed by the block
  bit          drain_next     = 1'b0;
  int          total_chars    = 0;
  int          chars_accepted = 0;
  int          lines_checked  = 0;
  int          error_count    = 0;
  int          cyc            = 0;
  logic        in_fire        = 1'b0;
  logic        quiet;

  assign quiet = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);

  // --------------------------------------------------------- line parser model
  logic [2:0] parse_ph = PH_START;
  logic [7:0] xor_acc  = 8'd0;
  logic [7:0] rx_val   = 8'd0;

  // -1 when c is not an upper-case hex digit
  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? CH_ZERO + {4'd0, n} : CH_UPPER_A + {4'd0, n - 4'd10};
  endfunction

  // Advance the parse by one character; on end of line give the status and
  // return to the start-of-line state.
  task automatic advance_line_parse(input logic [7:0] c, input logic eol,
                                    output bit line_done, output lxc_result_t res);
    int d;
    d         = hex_nibble(c);
    line_done = 1'b0;
    res       = '0;
    case (parse_ph)
      PH_START: begin
        parse_ph = (c == CH_DOLLAR) ? PH_XOR : PH_UNCHECKED;
      end
      PH_XOR: begin
        // only the first star closes the XOR span
        if (c == CH_STAR) parse_ph = PH_HEX1;
        else xor_acc = xor_acc ^ c;
      end
      PH_HEX1: begin
        if (d >= 0) begin
          rx_val   = d[7:0];
          parse_ph = PH_HEX2;
        end else begin
          parse_ph = PH_ERROR;
        end
      end
      PH_HEX2: begin
        if (d >= 0) begin
          rx_val   = {rx_val[3:0], d[3:0]};
          parse_ph = PH_DONE;
        end else begin
          parse_ph = PH_ERROR;
        end
      end
      PH_UNCHECKED: begin
      end
      default: begin
        // anything after the two digits, or after a fault
        parse_ph = PH_ERROR;
      end
    endcase
    if (eol) begin
      line_done = 1'b1;
      case (parse_ph)
        PH_XOR:       res.check_status = ST_ABSENT;
        PH_DONE:      res.check_status = (xor_acc == rx_val) ? ST_OK : ST_MISMATCH;
        PH_UNCHECKED: res.check_status = ST_UNCHECKED;
        default:      res.check_status = ST_SYNTAX;
      endcase
      res.computed_xor = (res.check_status == ST_UNCHECKED) ? 8'd0 : xor_acc;
      res.received_xor = (res.check_status == ST_UNCHECKED ||
                          res.check_status == ST_ABSENT) ? 8'd0 : rx_val;
      parse_ph = PH_START;
      xor_acc  = 8'd0;
      rx_val   = 8'd0;
    end
  endtask

  // ------------------------------------------------------- stimulus building
  task automatic put(input logic [7:0] c);
    char_txn_t t;
    t.ch       = c;
    t.eol      = 1'b0;
    t.drain    = drain_next;
    drain_next = 1'b0;
    line_buf.push_back(t);
  endtask

  task automatic put_hex(input logic [7:0] v);
    put(hex_char(v[7:4]));
    put(hex_char(v[3:0]));
  endtask

  task automatic close_line();
    line_buf[line_buf.size() - 1].eol = 1'b1;
    foreach (line_buf[i]) char_q.push_back(line_buf[i]);
    line_buf.delete();
  endtask

  task automatic queue_random_line();
    int         kind;
    int         len;
    logic [7:0] c;
    logic [7:0] sum;
    sum  = 8'd0;
    kind = $urandom_range(0, 99);
    if (kind >= 85) begin
      // unchecked line: anything but '$' first, then anything at all
      do c = 8'($urandom_range(0, 255)); while (c == CH_DOLLAR);
      put(c);
      len = $urandom_range(0, 8);
      repeat (len) put(8'($urandom_range(0, 255)));
    end else begin
      put(CH_DOLLAR);
      len = $urandom_range(0, 10);
      repeat (len) begin
        do c = 8'($urandom_range(0, 255)); while (c == CH_STAR);
        put(c);
        sum = sum ^ c;
      end
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        put(CH_STAR);
        put_hex(sum);
      end else if (kind < 60) begin
        c = 8'($urandom_range(1, 255));
        put(CH_STAR);
        put_hex(sum ^ c);
      end else if (kind < 70) begin
        // no checksum at all
      end else if (kind < 75) begin
        put(CH_STAR);
      end else if (kind < 80) begin
        put(CH_STAR);
        put(hex_char(4'($urandom_range(0, 15))));
      end else if (kind < 85) begin
        // lower-case digit, first or second
        put(CH_STAR);
        if ($urandom_range(0, 1)) put(hex_char(sum[7:4]));
        put(CH_LOWER_A + 8'($urandom_range(0, 5)));
      end else if (kind < 93) begin
        put(CH_STAR);
        put_hex(sum);
        len = $urandom_range(1, 3);
        repeat (len) put(8'($urandom_range(0, 255)));
      end else begin
        put(CH_STAR);
        if ($urandom_range(0, 1)) put(hex_char(4'($urandom_range(0, 15))));
        do c = 8'($urandom_range(0, 255)); while (hex_nibble(c) >= 0);
        put(c);
        if ($urandom_range(0, 1)) put(8'($urandom_range(0, 255)));
      end
    end
    close_line();
  endtask

  // ------------------------------------------------------------------ driver
  // A character is offered, then held until the monitor saw it taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      line_char   <= 8'd0;
      end_of_line <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (char_q.size() != 0 &&
          (!char_q[0].drain || pending_status_q.size() == 0) &&
          (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_valid    <= 1'b1;
        line_char   <= char_q[0].ch;
        end_of_line <= char_q[0].eol;
        void'(char_q.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && lines_checked >= HOLD_AFTER) begin
      // long hold-off: output register fills, input must stall
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // ----------------------------------------------------------------- monitor
  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= SHOW_ERRORS) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    lxc_result_t exp_res;
    lxc_result_t new_res;
    bit          line_done;
    cyc <= cyc + 1;
    if (rst) begin
      in_fire  <= 1'b0;
      parse_ph = PH_START;
      xor_acc  = 8'd0;
      rx_val   = 8'd0;
    end else begin
      in_fire <= in_valid && in_ready;
      // output first: a status can never come from this edge's character
      if (out_valid && out_ready) begin
        lines_checked++;
        if (pending_status_q.size() == 0) begin
          flag_error($sformatf("status %0d with no line pending", check_status));
        end else begin
          exp_res = pending_status_q.pop_front();
          if (check_status !== exp_res.check_status ||
              computed_xor !== exp_res.computed_xor ||
              received_xor !== exp_res.received_xor) begin
            flag_error($sformatf(
              "line %0d: status exp %0d got %0d, computed exp %h got %h, received exp %h got %h",
              lines_checked, exp_res.check_status, check_status,
              exp_res.computed_xor, computed_xor, exp_res.received_xor, received_xor));
          end
        end
      end
      if (in_valid && in_ready) begin
        chars_accepted++;
        advance_line_parse(line_char, end_of_line, line_done, new_res);
        if (line_done) pending_status_q.push_back(new_res);
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    int directed_chars;

    // lone dollar
    put(CH_DOLLAR); close_line();
    // unchecked line, top character value
    put(8'hFF); close_line();
    // star at line end
    put(CH_DOLLAR); put(CH_STAR); close_line();
    // one digit then a later star in the digit slot
    put(CH_DOLLAR); put(CH_STAR); put(hex_char(4'd4)); put(CH_STAR); close_line();
    // lower-case digit
    put(CH_DOLLAR); put(CH_STAR); put(CH_LOWER_A); close_line();
    // NUL as data, checksum 00 matches
    put(CH_DOLLAR); put(8'h00); put(CH_STAR); put_hex(8'h00); close_line();
    // mismatch, digits up to 'F'
    put(CH_DOLLAR); put(8'h80); put(CH_STAR); put_hex(8'h7F); close_line();
    // good checksum followed by a trailing character
    put(CH_DOLLAR); put(CH_UPPER_A); put(CH_STAR); put_hex(CH_UPPER_A);
    put(CH_UPPER_X); close_line();
    directed_chars = char_q.size();

    // first random line waits for the directed statuses to drain
    drain_next = 1'b1;
    while (char_q.size() < directed_chars + DRAIN_AT) queue_random_line();
    drain_next = 1'b1;
    while (char_q.size() < directed_chars + RANDOM_CHARS) queue_random_line();
    total_chars = char_q.size();

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    while (chars_accepted < total_chars || pending_status_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (error_count == 0 && pending_status_q.size() == 0) begin
      $display("PASS line_xor_checksum_checker");
    end else begin
      $display("FAIL line_xor_checksum_checker");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("FAIL line_xor_checksum_checker");
    $finish;
  end

endmodule
